// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CC2AB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CC2AB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/cc2ab_pkg.sv -----
// Shared types and constants of the configuration record to Annex-B converter.
package cc2ab_pkg;

	localparam int unsigned MAX_OUT_SIZE = 1024;
	localparam int OFS_W = $clog2(MAX_OUT_SIZE);
	localparam int SUM_W = 18;
	localparam int SIZE_W = 10;

	localparam logic [4:0] AVC_HDR_LEN  = 5'd6;
	localparam logic [4:0] HEVC_HDR_LEN = 5'd22;
	localparam logic [4:0] ARR_SKIP_LEN = 5'd3;
	localparam logic [4:0] AVC_MIN_LEN  = 5'd8;
	localparam logic [4:0] HEVC_MIN_LEN = 5'd23;
	localparam logic [4:0] CNT_SAT      = 5'd31;
	localparam logic [7:0] AVC_UNITS    = 8'd2;

	localparam logic [7:0] SC_ZERO = 8'h00;
	localparam logic [7:0] SC_ONE  = 8'h01;
	localparam logic [2:0] SC_LEN  = 3'd4;

	typedef enum logic {
		MODE_AVC  = 1'b0,
		MODE_HEVC = 1'b1
	} mode_t;

	typedef enum logic [6:0] {
		PH_HDR   = 7'b0000001,
		PH_COUNT = 7'b0000010,
		PH_ASKIP = 7'b0000100,
		PH_LENHI = 7'b0001000,
		PH_LENLO = 7'b0010000,
		PH_COPY  = 7'b0100000,
		PH_DONE  = 7'b1000000
	} phase_t;

	// Results caused by one input byte.
	typedef struct packed {
		logic              sc;    // four start code beats
		logic              dat;   // one copied data beat
		logic [7:0]        data;
		logic              st;    // status beat
		logic              bad;
		logic [SIZE_W-1:0] size;
	} res_t;

endpackage

// ----- hw/rtl/codec_config_to_annexb.sv -----
// Top level: configuration record to Annex-B byte stream converter.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata[7:0] in_byte, tlast in_last
//  m_*      out  m_tvalid/m_tready  tdata byte/status/size, tuser kind, tlast out_last
//  cfg_*    in   cfg_wen            cfg_wdata format_mode
//
// A skipped byte yields no beat, and beats leave one per cycle while m_tready is high.
// The length-low byte of a unit yields four start code beats, so the next byte
// waits until the output register has drained them and any status beat.
// The output register holds one byte's results and is reloaded as its last beat leaves.
// arst_n clears parser state, the mode register and the output beat flags at once.
// m_tready low holds the current beat and s_tready.
module codec_config_to_annexb import cc2ab_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_wdata,  // format_mode
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] in_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // [7:0] out_byte, [8] status, [18:9] total_size, zero above
	output logic        m_tuser,    // [0] kind
	output logic        m_tlast
);

	mode_t             mode_q;
	res_t              nxt;
	logic              take;
	logic              pop;
	logic              single;
	logic [2:0]        sc_cnt_q;
	logic              dat_q;
	logic              st_q;
	logic [7:0]        data_q;
	logic              bad_q;
	logic [SIZE_W-1:0] size_q;
	logic [7:0]        beat_byte;
	logic              beat_status;
	logic [SIZE_W-1:0] beat_size;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_AVC;
		end else if (cfg_wen) begin
			mode_q <= mode_t'(cfg_wdata);
		end
	end

	cc2ab_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_byte (s_tdata),
		.in_last (s_tlast),
		.mode    (mode_q),
		.res     (nxt)
	);

	assign m_tvalid = (sc_cnt_q != 3'd0) || dat_q || st_q;
	assign single   = ((sc_cnt_q == 3'd1) && !dat_q && !st_q) ||
		((sc_cnt_q == 3'd0) && (dat_q ^ st_q));
	assign pop      = m_tvalid && m_tready;
	assign s_tready = !m_tvalid || (m_tready && single);
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_cnt_q <= '0;
			dat_q    <= 1'b0;
			st_q     <= 1'b0;
		end else if (take) begin
			sc_cnt_q <= nxt.sc ? SC_LEN : 3'd0;
			dat_q    <= nxt.dat;
			st_q     <= nxt.st;
		end else if (pop) begin
			if (sc_cnt_q != 3'd0) begin
				sc_cnt_q <= sc_cnt_q - 3'd1;
			end else if (dat_q) begin
				dat_q <= 1'b0;
			end else begin
				st_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_q <= nxt.data;
			bad_q  <= nxt.bad;
			size_q <= nxt.size;
		end
	end

	always_comb begin
		beat_byte   = 8'd0;
		beat_status = 1'b0;
		beat_size   = '0;
		m_tuser     = 1'b0;
		m_tlast     = 1'b0;
		if (sc_cnt_q != 3'd0) begin
			beat_byte = (sc_cnt_q == 3'd1) ? SC_ONE : SC_ZERO;
		end else if (dat_q) begin
			beat_byte = data_q;
		end else if (st_q) begin
			m_tuser     = 1'b1;
			m_tlast     = 1'b1;
			beat_status = bad_q;
			beat_size   = size_q;
		end
	end

	assign m_tdata = {5'd0, beat_size, beat_status, beat_byte};

endmodule

// ----- hw/rtl/cc2ab_parser.sv -----
// Record parser: per-byte state update and result set for one input byte.
module cc2ab_parser import cc2ab_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  mode_t      mode,
	output res_t       res
);

	phase_t             phase_q, phase_n;
	logic [4:0]         hc_q, hc_n, hc_inc;
	logic [15:0]        len_q, len_n, len_full;
	logic [15:0]        left_q, left_n;
	logic [7:0]         arr_q, arr_n;
	logic [OFS_W-1:0]   ofs_q, ofs_n;
	logic [4:0]         cnt_q, cnt_n;
	logic               err_q, err_n;
	logic               fin;
	logic               bad;
	logic [SUM_W-1:0]   sum;

	always_comb begin
		phase_n  = phase_q;
		hc_n     = hc_q;
		len_n    = len_q;
		left_n   = left_q;
		arr_n    = arr_q;
		ofs_n    = ofs_q;
		err_n    = err_q;
		fin      = 1'b0;
		bad      = 1'b0;
		res      = '0;
		hc_inc   = hc_q + 5'd1;
		cnt_n    = (cnt_q != CNT_SAT) ? cnt_q + 5'd1 : cnt_q;
		len_full = {len_q[15:8], in_byte};
		sum      = SUM_W'(ofs_q) + SUM_W'(4) + SUM_W'(len_full);

		if (!err_q) begin
			case (phase_q)
				PH_HDR: begin
					hc_n = hc_inc;
					if (hc_inc >= ((mode == MODE_HEVC) ? HEVC_HDR_LEN : AVC_HDR_LEN)) begin
						hc_n = '0;
						if (mode == MODE_AVC) begin
							arr_n   = AVC_UNITS;
							phase_n = PH_LENHI;
						end else begin
							phase_n = PH_COUNT;
						end
					end
				end
				PH_COUNT: begin
					if (mode == MODE_AVC) begin
						phase_n = PH_LENHI;
					end else begin
						arr_n   = in_byte;
						hc_n    = '0;
						phase_n = (in_byte == 8'd0) ? PH_DONE : PH_ASKIP;
					end
				end
				PH_ASKIP: begin
					hc_n = hc_inc;
					if (hc_inc >= ARR_SKIP_LEN) begin
						hc_n    = '0;
						phase_n = PH_LENHI;
					end
				end
				PH_LENHI: begin
					len_n   = {in_byte, 8'd0};
					phase_n = PH_LENLO;
				end
				PH_LENLO: begin
					len_n = len_full;
					if (sum >= SUM_W'(MAX_OUT_SIZE)) begin
						err_n = 1'b1;
					end else begin
						res.sc = 1'b1;
						ofs_n  = ofs_q + OFS_W'(4);
						left_n = len_full;
						if (len_full == 16'd0) begin
							fin = 1'b1;
						end else begin
							phase_n = PH_COPY;
						end
					end
				end
				PH_COPY: begin
					res.dat  = 1'b1;
					res.data = in_byte;
					ofs_n    = ofs_q + OFS_W'(1);
					left_n   = left_q - 16'd1;
					if (left_q == 16'd1) begin
						fin = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		if (fin) begin
			arr_n = (arr_q != 8'd0) ? arr_q - 8'd1 : arr_q;
			if (arr_n == 8'd0) begin
				phase_n = PH_DONE;
			end else if (mode == MODE_AVC) begin
				phase_n = PH_COUNT;
			end else begin
				hc_n    = '0;
				phase_n = PH_ASKIP;
			end
		end

		if (in_last) begin
			bad = err_n || (phase_n != PH_DONE) ||
				(cnt_n <= ((mode == MODE_HEVC) ? HEVC_MIN_LEN : AVC_MIN_LEN));
			res.st   = 1'b1;
			res.bad  = bad;
			res.size = bad ? '0 : SIZE_W'(ofs_n);
			phase_n  = PH_HDR;
			hc_n     = '0;
			len_n    = '0;
			left_n   = '0;
			arr_n    = '0;
			ofs_n    = '0;
			cnt_n    = '0;
			err_n    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			hc_q    <= '0;
			len_q   <= '0;
			left_q  <= '0;
			arr_q   <= '0;
			ofs_q   <= '0;
			cnt_q   <= '0;
			err_q   <= 1'b0;
		end else if (take) begin
			phase_q <= phase_n;
			hc_q    <= hc_n;
			len_q   <= len_n;
			left_q  <= left_n;
			arr_q   <= arr_n;
			ofs_q   <= ofs_n;
			cnt_q   <= cnt_n;
			err_q   <= err_n;
		end
	end

endmodule

// ----- hw/rtl/cc2ab_chk.sv -----
// Port-level checker for the converter, bound to the top level.
`include "assert_macros.svh"

module cc2ab_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	`CC2AB_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output beat changed while stalled")
	`CC2AB_ASSERT_IMP(a_last_is_status, clk, arst_n, m_tvalid, m_tlast == m_tuser, "tlast and status kind disagree")
	`CC2AB_ASSERT_IMP(a_payload_clean, clk, arst_n, m_tvalid && !m_tuser, m_tdata[23:8] == 16'd0, "payload beat carries status bits")
	`CC2AB_ASSERT_IMP(a_error_no_size, clk, arst_n, m_tvalid && m_tuser && m_tdata[8], m_tdata[18:9] == 10'd0, "error status carries a size")
	`CC2AB_ASSERT_IMP(a_status_no_byte, clk, arst_n, m_tvalid && m_tuser, (m_tdata[7:0] == 8'd0) && (m_tdata[23:19] == 5'd0), "status beat carries data")

endmodule

bind codec_config_to_annexb cc2ab_chk u_cc2ab_chk (.*);
